// ===== rtl/core/grwc_pkg.sv =====
// ----------------------------------------------------------------------------
// grwc_pkg
// Shared types and constants for the grid ray walkability check unit.
// ----------------------------------------------------------------------------
package grwc_pkg;

  localparam int GridSide  = 64;
  localparam int CoordW    = $clog2(GridSide);
  localparam int CellCount = GridSide * GridSide;
  localparam int AddrW     = $clog2(CellCount);

  // item kinds
  localparam logic KindWrite = 1'b0;
  localparam logic KindRay   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CLEAR,
    ST_PREP,
    ST_RD,
    ST_CHECK,
    ST_STEP,
    ST_DIV,
    ST_STOP,
    ST_DONE
  } grwc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic wr_cell;
    logic clr_cell;
    logic prep;
    logic rd_start;
    logic rd_walk;
    logic seed;
    logic check;
    logic step;
    logic div_start;
    logic div_iter;
    logic fin_hit;
    logic fin_end;
    logic fin_start;
  } grwc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic kind;
    logic zero_len;
    logic cell_bad;
    logic climb_bad;
    logic no_step;
    logic past_end;
    logic div_last;
    logic div_first;
  } grwc_sts_t;

endpackage

// ===== rtl/core/grid_ray_walkability_check_unit.sv =====
// ----------------------------------------------------------------------------
// grid_ray_walkability_check_unit
// Cell table with ray walk over present, flag-masked, climbable cells.
// ----------------------------------------------------------------------------
// a cell write gives no result
// a ray checks the start cell first, then walks cell by cell through check, step and read;
// a ray blocked past the start cell adds the two 43-step stop point divisions
// the result strobe rises in the same cycle that busy falls; one item at a time
// after reset the cell table is cleared with busy high
module grid_ray_walkability_check_unit
  import grwc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               kind,
  input  logic [11:0]        cell_addr,
  input  logic               cell_present,
  input  logic signed [15:0] cell_height,
  input  logic [7:0]         cell_flags,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic [14:0]        ray_length,
  input  logic [7:0]         walk_mask,
  input  logic [14:0]        climb_limit,
  output logic               done,
  output logic signed [15:0] end_x,
  output logic signed [15:0] end_y,
  output logic               did_hit
);

  grwc_cmd_t cmd;
  grwc_sts_t sts;

  // sequencer
  grwc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .sts  (sts),
    .cmd  (cmd)
  );

  // datapath
  grwc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .kind        (kind),
    .cell_addr   (cell_addr),
    .cell_present(cell_present),
    .cell_height (cell_height),
    .cell_flags  (cell_flags),
    .start_x     (start_x),
    .start_y     (start_y),
    .dir_x       (dir_x),
    .dir_y       (dir_y),
    .ray_length  (ray_length),
    .walk_mask   (walk_mask),
    .climb_limit (climb_limit),
    .end_x       (end_x),
    .end_y       (end_y),
    .did_hit     (did_hit)
  );

endmodule

// ===== rtl/core/grwc_datapath.sv =====
// ----------------------------------------------------------------------------
// grwc_datapath
// Cell memory, ray setup, boundary stepping and stop point arithmetic.
// ----------------------------------------------------------------------------
module grwc_datapath
  import grwc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  grwc_cmd_t          cmd,
  output grwc_sts_t          sts,
  input  logic               kind,
  input  logic [11:0]        cell_addr,
  input  logic               cell_present,
  input  logic signed [15:0] cell_height,
  input  logic [7:0]         cell_flags,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic [14:0]        ray_length,
  input  logic [7:0]         walk_mask,
  input  logic [14:0]        climb_limit,
  output logic signed [15:0] end_x,
  output logic signed [15:0] end_y,
  output logic               did_hit
);

  // cell memory: present, height, flags
  logic [24:0] mem [CellCount];
  logic [24:0] rd_data;
  logic [AddrW-1:0] clr_addr;
  logic [AddrW-1:0] rd_addr;
  logic rd_oob;
  logic rd_oob_q;

  // captured item
  logic        k_q;
  logic [11:0] a_q;
  logic        p_q;
  logic signed [15:0] h_q;
  logic [7:0]  f_q;
  logic signed [15:0] sx, sy, dx, dy;
  logic [14:0] len;
  logic [7:0]  mask;
  logic [14:0] climb;

  // walk state
  logic signed [16:0] rdx, rdy;
  logic [16:0] ax, ay;
  logic signed [17:0] px, py;
  logic [23:0] nx, ny;
  logic signed [16:0] prev;
  logic [23:0] tn;
  logic [16:0] td;
  logic        use_x;

  // divider state: q = (2*|tn*rd| + td) / (2*td)
  logic [42:0] num;
  logic [42:0] rem;
  logic [33:0] quo;
  logic [33:0] quo_fin;
  logic [5:0]  div_cnt;
  logic        neg;

  logic signed [31:0] mx, my;
  logic signed [31:0] rx_full, ry_full;
  logic [31:0] mx_abs, my_abs;
  logic signed [16:0] rdx_c, rdy_c;
  logic signed [16:0] sxh, syh;
  logic signed [17:0] sx_r, sy_r;
  logic signed [17:0] rx0, ry0;
  logic [40:0] cmp_x, cmp_y;
  logic sxs, sys;
  logic signed [18:0] end_sum_x, end_sum_y;
  logic [16:0] rd_sel_abs;
  logic [40:0] prod;
  logic [43:0] trial;
  logic signed [35:0] qs;
  logic signed [36:0] fin_v;
  logic signed [17:0] hgt_lim;

  function automatic logic signed [15:0] sat16(input logic signed [36:0] v);
    if (v > 37'sd32767) return 16'sh7fff;
    if (v < -37'sd32768) return -16'sh8000;
    return v[15:0];
  endfunction

  // round q8.8 to nearest integer, halves away from zero
  function automatic logic signed [17:0] rnd88(input logic signed [15:0] v);
    logic [16:0] m;
    logic [16:0] r;
    m = v[15] ? 17'(-$signed({v[15], v})) : 17'({1'b0, v});
    r = (m + 17'd128) >> 8;
    return v[15] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  // rounded ray vector
  assign mx = dx * $signed({1'b0, len});
  assign my = dy * $signed({1'b0, len});
  assign mx_abs = mx[31] ? 32'(-mx) : 32'(mx);
  assign my_abs = my[31] ? 32'(-my) : 32'(my);
  assign rx_full = $signed((mx_abs + 32'd8192) >> 14);
  assign ry_full = $signed((my_abs + 32'd8192) >> 14);
  assign rdx_c = mx[31] ? -17'(rx_full) : 17'(rx_full);
  assign rdy_c = my[31] ? -17'(ry_full) : 17'(ry_full);

  assign sxh = 17'(sx) + 17'sd128;
  assign syh = 17'(sy) + 17'sd128;
  assign sx_r = rnd88(sx);
  assign sy_r = rnd88(sy);

  assign cmp_x = nx[23:0] * ay;
  assign cmp_y = ny[23:0] * ax;
  assign sxs = (ax != 0) && ((ay == 0) || (cmp_x <= cmp_y));
  assign sys = (ay != 0) && ((ax == 0) || (cmp_y <= cmp_x));

  // cell address selection
  always_comb begin
    rx0 = cmd.rd_start ? sx_r : px;
    ry0 = cmd.rd_start ? sy_r : py;
    rd_oob = (rx0 < 0) || (ry0 < 0) || (rx0 >= GridSide) || (ry0 >= GridSide);
    rd_addr = {ry0[CoordW-1:0], rx0[CoordW-1:0]};
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.clr_cell) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr_cell && ({1'b0, a_q} < 13'(CellCount))) begin
      mem[a_q[AddrW-1:0]] <= {p_q, h_q, f_q};
    end
    rd_data  <= mem[rd_addr];
    rd_oob_q <= rd_oob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_cell) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_q <= kind; a_q <= cell_addr; p_q <= cell_present;
      h_q <= cell_height; f_q <= cell_flags;
      sx <= start_x; sy <= start_y; dx <= dir_x; dy <= dir_y;
      len <= ray_length; mask <= walk_mask; climb <= climb_limit;
    end
  end

  assign hgt_lim = 18'(prev) + 18'($signed({1'b0, climb}));

  // status
  always_comb begin
    sts.clr_last  = &clr_addr;
    sts.kind      = k_q;
    sts.zero_len  = (len == 0);
    sts.cell_bad  = rd_oob_q || !rd_data[24] ||
                    ((mask != 0) && ((rd_data[7:0] & mask) == 0));
    sts.climb_bad = 18'($signed(rd_data[23:8])) > hgt_lim;
    sts.no_step   = (ax == 0) && (ay == 0);
    sts.past_end  = sxs ? ({1'b0, nx} > 25'(ax)) : ({1'b0, ny} > 25'(ay));
    sts.div_last  = (div_cnt == 6'd0);
    sts.div_first = use_x;
  end

  // ray setup and walk
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rdx <= rdx_c;
      rdy <= rdy_c;
      ax  <= rdx_c[16] ? 17'(-rdx_c) : 17'(rdx_c);
      ay  <= rdy_c[16] ? 17'(-rdy_c) : 17'(rdy_c);
      px  <= 18'(sxh >>> 8);
      py  <= 18'(syh >>> 8);
      nx  <= (rdx_c > 0) ? 24'(17'sd256 - 17'(sxh[7:0])) : 24'(sxh[7:0]);
      ny  <= (rdy_c > 0) ? 24'(17'sd256 - 17'(syh[7:0])) : 24'(syh[7:0]);
      tn  <= '0;
      td  <= 17'd1;
    end
    if (cmd.seed || cmd.check) begin
      prev <= 17'($signed(rd_data[23:8]));
    end
    if (cmd.step) begin
      tn <= sxs ? nx : ny;
      td <= sxs ? ax : ay;
      if (sxs) begin
        nx <= nx + 24'd256;
        px <= (rdx > 0) ? px + 18'sd1 : px - 18'sd1;
      end
      if (sys) begin
        ny <= ny + 24'd256;
        py <= (rdy > 0) ? py + 18'sd1 : py - 18'sd1;
      end
    end
  end

  // restoring divider for the stop point, x then y
  assign rd_sel_abs = use_x ? (rdx[16] ? 17'(-rdx) : 17'(rdx))
                            : (rdy[16] ? 17'(-rdy) : 17'(rdy));
  assign prod  = tn * rd_sel_abs;
  assign trial = {rem[41:0], num[42]} - {26'd0, td, 1'b0};
  // quotient including the bit decided in the current step
  assign quo_fin = {quo[32:0], ~trial[43]};
  assign qs    = neg ? -36'($signed({1'b0, quo_fin})) : 36'($signed({1'b0, quo_fin}));
  assign fin_v = 37'(use_x ? sx : sy) + 37'(qs);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      use_x <= 1'b1;
    end else if (cmd.div_iter && div_cnt == 6'd0) begin
      use_x <= 1'b0;
    end
    if (cmd.div_start) begin
      num     <= {1'b0, prod, 1'b0} + 43'(td);
      rem     <= '0;
      quo     <= '0;
      div_cnt <= 6'd42;
      neg     <= use_x ? rdx[16] : rdy[16];
    end else if (cmd.div_iter) begin
      if (!trial[43]) begin
        rem <= trial[42:0];
        quo <= {quo[32:0], 1'b1};
      end else begin
        rem <= {rem[41:0], num[42]};
        quo <= {quo[32:0], 1'b0};
      end
      num     <= {num[41:0], 1'b0};
      div_cnt <= div_cnt - 6'd1;
    end
  end

  // result registers
  assign end_sum_x = 19'(sx) + 19'(rdx);
  assign end_sum_y = 19'(sy) + 19'(rdy);

  always_ff @(posedge clk) begin
    if (cmd.fin_start) begin
      end_x <= sx; end_y <= sy; did_hit <= 1'b1;
    end
    if (cmd.fin_end) begin
      end_x <= sat16(37'(end_sum_x));
      end_y <= sat16(37'(end_sum_y));
      did_hit <= 1'b0;
    end
    if (cmd.fin_hit) begin
      did_hit <= 1'b1;
    end
    if (cmd.div_iter && div_cnt == 6'd0) begin
      if (use_x) end_x <= sat16(fin_v);
      else       end_y <= sat16(fin_v);
    end
  end

endmodule

// ===== rtl/core/grwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// grwc_ctrl
// Sequencer for cell writes, memory clear after reset and the ray walk.
// ----------------------------------------------------------------------------
module grwc_ctrl
  import grwc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  input  grwc_sts_t sts,
  output grwc_cmd_t cmd
);

  grwc_state_t state, state_next;
  logic        zl, zl_next;
  logic        done_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      zl    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      zl    <= zl_next;
      done  <= done_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    zl_next    = zl;
    done_next  = 1'b0;
    cmd        = '0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.kind == KindWrite) begin
          cmd.wr_cell = 1'b1;
          state_next  = ST_IDLE;
        end else begin
          cmd.rd_start = 1'b1;
          cmd.prep     = 1'b1;
          cmd.fin_start = 1'b1;
          zl_next      = sts.zero_len;
          state_next   = ST_PREP;
        end
      end
      ST_CLEAR: begin
        cmd.clr_cell = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_PREP: begin
        if (sts.cell_bad) begin
          done_next  = 1'b1;
          state_next = ST_IDLE;
        end else if (zl) begin
          cmd.fin_end = 1'b1;
          state_next  = ST_DONE;
        end else begin
          cmd.seed    = 1'b1;
          cmd.rd_walk = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_RD: begin
        cmd.rd_walk = 1'b1;
        state_next  = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.cell_bad || sts.climb_bad) begin
          cmd.fin_hit   = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.check  = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (sts.no_step || sts.past_end) begin
          cmd.fin_end = 1'b1;
          state_next  = ST_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = ST_RD;
        end
      end
      ST_DIV: begin
        cmd.div_iter = 1'b1;
        if (sts.div_last) begin
          state_next = sts.div_first ? ST_STOP : ST_DONE;
        end
      end
      ST_STOP: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DONE: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
